[src/pcg32_pkg.sv]
// Package for the PCG32 bounded random source: request codes, constants,
// controller/datapath command and status types. No dependencies.
package pcg32_pkg;

    localparam logic [2:0] KIND_RESEED  = 3'd0;
    localparam logic [2:0] KIND_STREAM  = 3'd1;
    localparam logic [2:0] KIND_RAW32   = 3'd2;
    localparam logic [2:0] KIND_RAW64   = 3'd3;
    localparam logic [2:0] KIND_BND32   = 3'd4;
    localparam logic [2:0] KIND_BND64   = 3'd5;
    localparam logic [2:0] KIND_RANGE   = 3'd6;
    localparam logic [2:0] KIND_COIN    = 3'd7;

    localparam logic [63:0] LCG_MULT = 64'd6364136223846793005;
    localparam logic [63:0] RESEED_INC = 64'd3;
    localparam int DIV_STEPS = 64;

    localparam logic [0:0] CFG_SEED   = 1'b0;
    localparam logic [0:0] CFG_STREAM = 1'b1;

    // Datapath commands issued by the controller.
    typedef struct packed {
        logic load;       // capture request operands, derive limit
        logic seed_zero;  // state <= 0, increment <= chosen value
        logic seed_add;   // state <= state + seed
        logic mul_start;  // capture old state for partial products
        logic mul_step;   // accumulate one partial product
        logic mul_commit; // state <= product + increment, capture output word
        logic draw_hi;    // shift drawn word into draw register
        logic div_thr;    // start divide of (-lim) by lim
        logic div_draw;   // start divide of draw by lim
        logic div_step;   // one restoring-divide step
        logic set_thr;    // threshold <= remainder
        logic finish;     // result register <= final value
        logic fin_zero;   // result is zero / lower
    } pcg_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       lim_zero;  // zero limit or empty range
        logic       accept;    // draw >= threshold
        logic       div_done;
        logic       mul_done;
    } pcg_sts_t;

endpackage

[src/pcg32_datapath.sv]
// Datapath of the PCG32 source: LCG state, 16x64 serial multiplier,
// radix-2 divider, draw/threshold registers. Depends on pcg32_pkg.
module pcg32_datapath
    import pcg32_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_idx,
    input  logic [63:0] cfg_data,
    input  logic [2:0]  kind,
    input  logic [63:0] bound,
    input  logic [63:0] lower,
    input  logic [63:0] upper,
    input  pcg_cmd_t    cmd,
    output pcg_sts_t    sts,
    output logic [63:0] result
);

    logic [63:0] seed_reg;
    logic [62:0] stream_reg;
    logic [63:0] state_reg, inc_reg;
    logic [2:0]  kind_reg;
    logic [63:0] lim_reg, lower_reg;
    logic        wide_reg, zero_reg;
    logic [63:0] old_reg, acc_reg;
    logic [1:0]  mcnt_reg;
    logic        mbusy_reg;
    logic [31:0] word_reg;
    logic [63:0] draw_reg, thr_reg;
    logic [63:0] quo_reg, rem_reg;
    logic [6:0]  dcnt_reg;
    logic [63:0] res_reg;

    logic [63:0] span, bnd_lim, new_lim;
    logic        empty;
    logic [31:0] xsh, rot_out;
    logic [4:0]  rot;
    logic [64:0] trial;
    logic [63:0] pprod;

    always_comb
    begin
        span  = upper - lower;
        empty = ($signed(upper) <= $signed(lower));
        bnd_lim = (bound > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : bound;
        case (kind)
            KIND_BND32: new_lim = bnd_lim;
            KIND_RANGE: new_lim = span;
            default:    new_lim = bound;
        endcase
        xsh = 32'(((old_reg >> 18) ^ old_reg) >> 27);
        rot = old_reg[63:59];
        rot_out = (xsh >> rot) | (xsh << ((6'd32 - {1'b0, rot}) & 6'd31));
        trial = {rem_reg, quo_reg[63]} - {1'b0, lim_reg};
        pprod = 64'(old_reg * 64'(LCG_MULT[mcnt_reg*16 +: 16])) << {mcnt_reg, 4'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= '0;
            stream_reg <= 63'd1;
            state_reg  <= '0;
            inc_reg    <= RESEED_INC;
            mbusy_reg  <= 1'b0;
            mcnt_reg   <= '0;
            dcnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_SEED:   seed_reg   <= cfg_data;
                    CFG_STREAM: stream_reg <= cfg_data[62:0];
                    default:    ;
                endcase
            end
            if (cmd.seed_zero)
            begin
                state_reg <= '0;
                inc_reg   <= (kind_reg == KIND_RESEED) ? RESEED_INC : {stream_reg, 1'b1};
            end
            if (cmd.seed_add)
                state_reg <= state_reg + ((kind_reg == KIND_RESEED) ? seed_reg : lower_reg);
            if (cmd.mul_start)
            begin
                mbusy_reg <= 1'b1;
                mcnt_reg  <= '0;
            end
            else if (cmd.mul_step && mbusy_reg)
            begin
                mcnt_reg <= mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd3)
                    mbusy_reg <= 1'b0;
            end
            if (cmd.mul_commit)
                state_reg <= acc_reg + inc_reg;
            if (cmd.div_thr || cmd.div_draw)
                dcnt_reg <= 7'(DIV_STEPS);
            else if (cmd.div_step && dcnt_reg != 0)
                dcnt_reg <= dcnt_reg - 7'd1;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            lim_reg   <= new_lim;
            lower_reg <= lower;
            wide_reg  <= (kind != KIND_BND32);
            zero_reg  <= (kind == KIND_RANGE) ? empty : (new_lim == 64'd0);
        end
        // Hold the current state as the stream seed; the first seeding step
        // multiplies a zero state.
        if (cmd.seed_zero)
            lower_reg <= state_reg;
        if (cmd.mul_start)
        begin
            old_reg <= cmd.seed_zero ? 64'd0 : state_reg;
            acc_reg <= '0;
        end
        else if (cmd.mul_step && mbusy_reg)
            acc_reg <= acc_reg + pprod;
        if (cmd.mul_commit)
            word_reg <= rot_out;
        if (cmd.draw_hi)
            draw_reg <= {draw_reg[31:0], word_reg};
        if (cmd.div_thr || cmd.div_draw)
        begin
            rem_reg <= '0;
            if (cmd.div_thr)
                quo_reg <= wide_reg ? (64'd0 - lim_reg) : {32'd0, 32'(32'd0 - lim_reg[31:0])};
            else
                quo_reg <= wide_reg ? draw_reg : {32'd0, draw_reg[31:0]};
        end
        else if (cmd.div_step && dcnt_reg != 0)
        begin
            if (!trial[64])
                rem_reg <= trial[63:0];
            else
                rem_reg <= {rem_reg[62:0], quo_reg[63]};
            quo_reg <= {quo_reg[62:0], 1'b0};
        end
        if (cmd.set_thr)
            thr_reg <= rem_reg;
        if (cmd.finish)
        begin
            unique case (kind_reg)
                KIND_RESEED, KIND_STREAM: res_reg <= '0;
                KIND_RAW32: res_reg <= {32'd0, draw_reg[31:0]};
                KIND_RAW64: res_reg <= draw_reg;
                KIND_COIN:  res_reg <= {63'd0, draw_reg[0]};
                KIND_RANGE: res_reg <= cmd.fin_zero ? lower_reg : lower_reg + rem_reg;
                default:    res_reg <= cmd.fin_zero ? 64'd0 : rem_reg;
            endcase
        end
    end

    assign sts.kind     = kind_reg;
    assign sts.lim_zero = zero_reg;
    assign sts.accept   = wide_reg ? (draw_reg >= thr_reg) : (draw_reg[31:0] >= thr_reg[31:0]);
    assign sts.div_done = (dcnt_reg == 0);
    assign sts.mul_done = !mbusy_reg;
    assign result       = res_reg;

endmodule

[src/pcg32_controller.sv]
// Sequencer of the PCG32 source: walks seeding, draws, threshold and
// reduction divides. Depends on pcg32_pkg.
module pcg32_controller
    import pcg32_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  pcg_sts_t sts,
    output pcg_cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_COMM  = 4'd3;
    localparam logic [3:0] S_THR   = 4'd4;
    localparam logic [3:0] S_THRW  = 4'd5;
    localparam logic [3:0] S_CHK   = 4'd6;
    localparam logic [3:0] S_RED   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_SEEDA = 4'd10;

    logic [3:0] state_reg, state_next;
    // Gen step count: seeding uses two steps, 64-bit draws two words.
    logic [1:0] step_reg, step_next;
    logic       seeded_reg, seeded_next;
    logic       ovalid_reg, ovalid_next;

    logic need2;
    assign need2 = (sts.kind == KIND_RAW64) || (sts.kind == KIND_BND64)
                || (sts.kind == KIND_RANGE);

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        step_next   = step_reg;
        seeded_next = seeded_reg;
        ovalid_next = ovalid_reg && out_stall;
        in_stall    = !(state_reg == S_IDLE) || (ovalid_reg && out_stall);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                step_next   = '0;
                seeded_next = 1'b0;
                if (sts.kind == KIND_RESEED || sts.kind == KIND_STREAM)
                begin
                    state_next = S_SEEDA;
                end
                else if ((sts.kind == KIND_BND32 || sts.kind == KIND_BND64
                          || sts.kind == KIND_RANGE) && sts.lim_zero)
                begin
                    cmd.fin_zero = 1'b1;
                    cmd.finish   = 1'b1;
                    state_next   = S_OUT;
                end
                else if (sts.kind == KIND_BND32 || sts.kind == KIND_BND64
                         || sts.kind == KIND_RANGE)
                begin
                    cmd.div_thr = 1'b1;
                    state_next  = S_THRW;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_SEEDA:
            begin
                // Hold current state as seed, clear state, step from zero.
                cmd.seed_zero = 1'b1;
                cmd.mul_start = 1'b1;
                state_next    = S_MUL;
            end
            S_THRW:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    cmd.set_thr   = 1'b1;
                    cmd.mul_start = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (sts.mul_done)
                    state_next = S_COMM;
            end
            S_COMM:
            begin
                cmd.mul_commit = 1'b1;
                state_next     = S_THR;
            end
            S_THR:
            begin
                step_next = step_reg + 2'd1;
                if (sts.kind == KIND_RESEED || sts.kind == KIND_STREAM)
                begin
                    if (!seeded_reg)
                    begin
                        cmd.seed_add  = 1'b1;
                        seeded_next   = 1'b1;
                        state_next    = S_FIN;
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    cmd.draw_hi = 1'b1;
                    if (need2 && step_reg == 2'd0)
                        state_next = S_FIN;
                    else if (sts.kind == KIND_BND32 || sts.kind == KIND_BND64
                             || sts.kind == KIND_RANGE)
                        state_next = S_CHK;
                    else
                    begin
                        state_next = S_RED;
                        step_next  = 2'd3;
                    end
                end
            end
            S_FIN:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_MUL;
            end
            S_CHK:
            begin
                step_next = '0;
                if (sts.accept)
                begin
                    cmd.div_draw = 1'b1;
                    state_next   = S_RED;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_RED:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == 2'd3 || sts.div_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            step_reg   <= '0;
            seeded_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            seeded_reg <= seeded_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

endmodule

[src/pcg32_bounded_random_source_unit.sv]
// PCG32 bounded random source, top level. Depends on pcg32_pkg,
// pcg32_controller and pcg32_datapath.
// A generator step runs the 16x64 serial multiplier, then commits the new
// state; raw32 and coin draw one word, raw64 two; reseed and stream switch
// clear the state, step it, add the seed and step again; zero bound or empty
// range finish without a step; bounded draws run two divides and redraw on reject.
// One request at a time; the result register holds the beat while stalled,
// and the next request can be taken in the cycle the beat leaves.
// Reset: state 0, increment 3 (stream 1), seed 0, stream select 1.
module pcg32_bounded_random_source_unit
    import pcg32_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [63:0] bound,
    input  logic [63:0] lower,
    input  logic [63:0] upper,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] value
);

    pcg_cmd_t cmd;
    pcg_sts_t sts;

    // Sequencer: owns the handshakes and the request flow.
    pcg32_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Generator state, multiplier, divider and result register.
    pcg32_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_index),
        .cfg_data (cfg_data),
        .kind     (kind),
        .bound    (bound),
        .lower    (lower),
        .upper    (upper),
        .cmd      (cmd),
        .sts      (sts),
        .result   (value)
    );

endmodule
